FILE: rtl/core/aoet_pkg.sv
// ----------------------------------------------------------------------------
// aoet_pkg: shared types and constants for the box collision query unit
// function codes, register indexes and per-axis flag bundle
// ----------------------------------------------------------------------------
package aoet_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int DIST_W          = 64;
  localparam int FUNC_W          = 3;
  localparam int CFG_INDEX_W     = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_SPHERE_OVERLAP  = 3'd0,
    FN_BOX_OVERLAP     = 3'd1,
    FN_ENCLOSES_SPHERE = 3'd2,
    FN_ENCLOSES_BOX    = 3'd3,
    FN_INSIDE_SPHERE   = 3'd4,
    FN_INSIDE_BOX      = 3'd5,
    FN_DISTANCE        = 3'd6
  } func_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_HALF_X   = 3'd3,
    REG_HALF_Y   = 3'd4,
    REG_HALF_Z   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic overlap;
    logic encl_sphere;
    logic encl_box;
    logic inside_sphere;
    logic inside_box;
  } axis_flags_t;

endpackage

FILE: rtl/core/aoet_if.sv
// ----------------------------------------------------------------------------
// aoet_if: query and result channels
// valid/ready channels carrying one query word and one result word
// ----------------------------------------------------------------------------
interface aoet_query_if import aoet_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic [FUNC_W-1:0]             func;
  logic signed [COORD_WIDTH-1:0] other_center_x;
  logic signed [COORD_WIDTH-1:0] other_center_y;
  logic signed [COORD_WIDTH-1:0] other_center_z;
  logic [COORD_WIDTH-2:0]        other_extent_x;
  logic [COORD_WIDTH-2:0]        other_extent_y;
  logic [COORD_WIDTH-2:0]        other_extent_z;

  modport source (
    output valid, func, other_center_x, other_center_y, other_center_z,
           other_extent_x, other_extent_y, other_extent_z,
    input  ready
  );
  modport sink (
    input  valid, func, other_center_x, other_center_y, other_center_z,
           other_extent_x, other_extent_y, other_extent_z,
    output ready
  );
endinterface

interface aoet_result_if import aoet_pkg::*;;
  logic              valid;
  logic              ready;
  logic              test_true;
  logic [DIST_W-1:0] squared_distance;
  logic              distance_saturated;

  modport source (
    output valid, test_true, squared_distance, distance_saturated,
    input  ready
  );
  modport sink (
    input  valid, test_true, squared_distance, distance_saturated,
    output ready
  );
endinterface

FILE: rtl/core/aoet_axis.sv
// ----------------------------------------------------------------------------
// aoet_axis: one axis of the box query
// squared gap to the box slab and the per-axis overlap and enclosure flags
// ----------------------------------------------------------------------------
module aoet_axis import aoet_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int SW = COORD_WIDTH + 2,
  localparam int EW = COORD_WIDTH + 1,
  localparam int PW = 2 * EW
) (
  input  logic signed [COORD_WIDTH-1:0] box_center,
  input  logic [COORD_WIDTH-2:0]        box_half,
  input  logic signed [COORD_WIDTH-1:0] other_center,
  input  logic [COORD_WIDTH-2:0]        other_extent,
  input  logic [COORD_WIDTH-2:0]        radius,
  output logic [PW-1:0]                 gap_sq,
  output axis_flags_t                   flags
);

  logic signed [SW-1:0] c, h, oc, oe, r;
  logic signed [SW-1:0] lo, hi, gap_s, d, d_abs, reach;
  logic [PW-1:0]        gap;

  // everything widened to hold a centre plus or minus a half extent
  assign c  = SW'(box_center);
  assign h  = SW'(box_half);
  assign oc = SW'(other_center);
  assign oe = SW'(other_extent);
  assign r  = SW'(radius);

  assign lo = c - h;
  assign hi = c + h;

  always_comb begin
    if (oc < lo) begin
      gap_s = lo - oc;
    end else if (oc > hi) begin
      gap_s = oc - hi;
    end else begin
      gap_s = '0;
    end
  end

  assign gap    = PW'(gap_s[EW-1:0]);
  assign gap_sq = gap * gap;

  assign d     = c - oc;
  assign d_abs = (d < 0) ? -d : d;
  assign reach = h + oe;

  assign flags.overlap       = (d_abs <= reach);
  assign flags.encl_sphere   = !((oc - r < lo) || (oc + r > hi));
  assign flags.encl_box      = !((oc - oe < lo) || (oc + oe > hi));
  assign flags.inside_sphere = !((oc - r > lo) || (oc + r < hi));
  assign flags.inside_box    = !((oc - oe > lo) || (oc + oe < hi));

endmodule

FILE: rtl/core/aoet_eval.sv
// ----------------------------------------------------------------------------
// aoet_eval: result evaluation
// sums the axis gaps, saturates the distance and selects the test outcome
// ----------------------------------------------------------------------------
module aoet_eval import aoet_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int PW    = 2 * (COORD_WIDTH + 1),
  localparam int SUM_W = PW + 2,
  localparam int EXT_W = (SUM_W > DIST_W) ? SUM_W : DIST_W + 1,
  localparam int RW    = 2 * (COORD_WIDTH - 1)
) (
  input  logic [PW-1:0]          gap_sq_x,
  input  logic [PW-1:0]          gap_sq_y,
  input  logic [PW-1:0]          gap_sq_z,
  input  axis_flags_t            flags_x,
  input  axis_flags_t            flags_y,
  input  axis_flags_t            flags_z,
  input  logic [COORD_WIDTH-2:0] radius,
  input  logic [FUNC_W-1:0]      func,
  output logic                   test_true,
  output logic [DIST_W-1:0]      squared_distance,
  output logic                   distance_saturated
);

  logic [SUM_W-1:0] dist_sum;
  logic [EXT_W-1:0] dist_ext;
  logic [RW-1:0]    r_ext;
  logic [RW-1:0]    r_sq;
  axis_flags_t      all_axes;

  assign dist_sum = SUM_W'(gap_sq_x) + SUM_W'(gap_sq_y) + SUM_W'(gap_sq_z);
  assign dist_ext = EXT_W'(dist_sum);

  assign r_ext = RW'(radius);
  assign r_sq  = r_ext * r_ext;

  assign all_axes = flags_x & flags_y & flags_z;

  // clip at the top of the output range
  assign distance_saturated = |dist_ext[EXT_W-1:DIST_W];
  assign squared_distance   = distance_saturated ? '1 : dist_ext[DIST_W-1:0];

  always_comb begin
    unique case (func_t'(func))
      FN_SPHERE_OVERLAP:  test_true = (dist_ext <= EXT_W'(r_sq));
      FN_BOX_OVERLAP:     test_true = all_axes.overlap;
      FN_ENCLOSES_SPHERE: test_true = all_axes.encl_sphere;
      FN_ENCLOSES_BOX:    test_true = all_axes.encl_box;
      FN_INSIDE_SPHERE:   test_true = all_axes.inside_sphere;
      FN_INSIDE_BOX:      test_true = all_axes.inside_box;
      FN_DISTANCE:        test_true = 1'b0;
      default:            test_true = 1'b0;
    endcase
  end

endmodule

FILE: rtl/core/aabb_overlap_enclosure_test_top.sv
// a query word accepted is registered in the input stage, then in the result stage, before its result word is offered
// throughput: one query word per cycle, stalling only when the result word is not taken
// the rate is set by one combinational pass: per-axis gap multiplier, three-term add, compare
// reset: the pipeline empties and all six box registers return to zero
// ----------------------------------------------------------------------------
// aabb_overlap_enclosure_test_top: box collision query unit
// overlap, enclosure and squared distance queries against one configured box
// ----------------------------------------------------------------------------
module aabb_overlap_enclosure_test_top import aoet_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int PW = 2 * (COORD_WIDTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0] cfg_data,
  aoet_query_if.sink             query,
  aoet_result_if.source          result
);

  // box held in configuration
  logic signed [COORD_WIDTH-1:0] box_center_x, box_center_y, box_center_z;
  logic [COORD_WIDTH-2:0]        box_half_x, box_half_y, box_half_z;

  // input register stage
  logic                          s1_valid;
  logic [FUNC_W-1:0]             s1_func;
  logic signed [COORD_WIDTH-1:0] s1_center_x, s1_center_y, s1_center_z;
  logic [COORD_WIDTH-2:0]        s1_extent_x, s1_extent_y, s1_extent_z;

  // result register stage
  logic              out_valid;
  logic              out_test;
  logic [DIST_W-1:0] out_dist;
  logic              out_sat;

  // combinational pass
  logic [PW-1:0]     gap_sq_x, gap_sq_y, gap_sq_z;
  axis_flags_t       flags_x, flags_y, flags_z;
  logic              test_true;
  logic [DIST_W-1:0] squared_distance;
  logic              distance_saturated;

  logic advance;
  logic query_accept;

  // the result stage moves whenever it is empty or being drained
  assign advance      = !out_valid || result.ready;
  assign query.ready  = !s1_valid || advance;
  assign query_accept = query.valid && query.ready;

  // configuration writes; spare indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      box_center_x <= '0;
      box_center_y <= '0;
      box_center_z <= '0;
      box_half_x   <= '0;
      box_half_y   <= '0;
      box_half_z   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CENTER_X: box_center_x <= cfg_data;
        REG_CENTER_Y: box_center_y <= cfg_data;
        REG_CENTER_Z: box_center_z <= cfg_data;
        REG_HALF_X:   box_half_x   <= cfg_data[COORD_WIDTH-2:0];
        REG_HALF_Y:   box_half_y   <= cfg_data[COORD_WIDTH-2:0];
        REG_HALF_Z:   box_half_z   <= cfg_data[COORD_WIDTH-2:0];
        default: begin
        end
      endcase
    end
  end

  // input stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (query_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // input stage payload, no reset needed
  always_ff @(posedge clk) begin
    if (query_accept) begin
      s1_func     <= query.func;
      s1_center_x <= query.other_center_x;
      s1_center_y <= query.other_center_y;
      s1_center_z <= query.other_center_z;
      s1_extent_x <= query.other_extent_x;
      s1_extent_y <= query.other_extent_y;
      s1_extent_z <= query.other_extent_z;
    end
  end

  // one slice per axis; the sphere radius travels in the x extent
  aoet_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis_x (
    .box_center   (box_center_x),
    .box_half     (box_half_x),
    .other_center (s1_center_x),
    .other_extent (s1_extent_x),
    .radius       (s1_extent_x),
    .gap_sq       (gap_sq_x),
    .flags        (flags_x)
  );

  aoet_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis_y (
    .box_center   (box_center_y),
    .box_half     (box_half_y),
    .other_center (s1_center_y),
    .other_extent (s1_extent_y),
    .radius       (s1_extent_x),
    .gap_sq       (gap_sq_y),
    .flags        (flags_y)
  );

  aoet_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis_z (
    .box_center   (box_center_z),
    .box_half     (box_half_z),
    .other_center (s1_center_z),
    .other_extent (s1_extent_z),
    .radius       (s1_extent_x),
    .gap_sq       (gap_sq_z),
    .flags        (flags_z)
  );

  aoet_eval #(.COORD_WIDTH(COORD_WIDTH)) u_eval (
    .gap_sq_x           (gap_sq_x),
    .gap_sq_y           (gap_sq_y),
    .gap_sq_z           (gap_sq_z),
    .flags_x            (flags_x),
    .flags_y            (flags_y),
    .flags_z            (flags_z),
    .radius             (s1_extent_x),
    .func               (s1_func),
    .test_true          (test_true),
    .squared_distance   (squared_distance),
    .distance_saturated (distance_saturated)
  );

  // result stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  // result stage payload
  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_test <= test_true;
      out_dist <= squared_distance;
      out_sat  <= distance_saturated;
    end
  end

  assign result.valid              = out_valid;
  assign result.test_true          = out_test;
  assign result.squared_distance   = out_dist;
  assign result.distance_saturated = out_sat;

  // a clipped distance always reads as the maximum value
  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_sat |-> (&out_dist))
    else $error("saturated distance is not all ones");

  // pipeline is empty straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid && !s1_valid))
    else $error("pipeline not empty after reset");

  // an accepted query word always lands in the input stage
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    query_accept |=> s1_valid)
    else $error("accepted query word lost");

  // a word leaving the input stage always appears in the result stage
  a_move_out: assert property (@(posedge clk) disable iff (rst)
    s1_valid && advance |=> out_valid)
    else $error("word dropped between stages");

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the box collision query unit
// drives query words against a configured box and checks every result word
// against a behavioural predictor of the overlap, enclosure and distance logic
// ----------------------------------------------------------------------------
module tb;
  import aoet_pkg::*;

  localparam int CW              = COORD_WIDTH_DEF;
  localparam int LATENCY         = 2;
  localparam int NUM_PHASES      = 11;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int PRESSURE_PHASE  = 3;
  localparam int QUIET_PHASE     = 5;
  localparam int LONG_HOLD       = 64;
  localparam int IDLE_PCT        = 29;

  // selector with no operation behind it, and register indexes past the last
  localparam logic [FUNC_W-1:0]      FN_UNUSED   = 3'd7;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-2:0]        E_MAX = '1;
  localparam logic [CW-2:0]        UNIT  = (CW-1)'(1 << 16);

  typedef struct packed {
    logic [FUNC_W-1:0]      func;
    logic signed [CW-1:0]   cx;
    logic signed [CW-1:0]   cy;
    logic signed [CW-1:0]   cz;
    logic [CW-2:0]          ex;
    logic [CW-2:0]          ey;
    logic [CW-2:0]          ez;
  } query_t;

  typedef struct packed {
    logic              test_true;
    logic [DIST_W-1:0] squared_distance;
    logic              distance_saturated;
  } answer_t;

  typedef enum {ROW_QUERY, ROW_BOX} row_kind_t;

  // a box row loads centre from cx..cz and half extents from ex..ez
  typedef struct {
    row_kind_t kind;
    query_t    q;
    bit        typed;
    answer_t   ans;
  } stim_row_t;

  logic          clk = 1'b0;
  logic          rst;
  logic          cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CW-1:0] cfg_data;

  aoet_query_if #(.COORD_WIDTH(CW)) query_ch ();
  aoet_result_if                    result_ch ();

  aabb_overlap_enclosure_test_top #(.COORD_WIDTH(CW)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .query     (query_ch),
    .result    (result_ch)
  );

  // bench copy of the box registers
  logic signed [CW-1:0] box_ctr [3];
  logic [CW-2:0]        box_half [3];

  answer_t   pending_answers [$];
  stim_row_t directed_rows [$];

  int  mismatches    = 0;
  int  words_sent    = 0;
  int  words_checked = 0;
  int  reg_writes    = 0;
  int  box_settings  = 0;
  int  true_results  = 0;
  int  sat_results   = 0;
  bit  gaps_on       = 1'b1;
  bit  hold_request  = 1'b0;

  // 10 unit period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop well past the slowest legal run
  initial begin
    #3000000;
    $display("tb: FAIL");
    $finish;
  end

  function automatic longint rand_below(longint n);
    return longint'({1'b0, 31'($urandom), $urandom}) % n;
  endfunction

  // expected result word for one query against the current box
  function automatic answer_t predict_answer(query_t q);
    longint       oc [3];
    longint       oe [3];
    longint       c, h, lo, hi, d, r;
    logic [127:0] acc, e;
    logic         ovl, enc_s, enc_b, ins_s, ins_b, hit;
    answer_t      a;
    oc[0] = longint'($signed(q.cx));
    oc[1] = longint'($signed(q.cy));
    oc[2] = longint'($signed(q.cz));
    oe[0] = longint'(q.ex);
    oe[1] = longint'(q.ey);
    oe[2] = longint'(q.ez);
    r     = oe[0];
    acc   = '0;
    ovl   = 1'b1;
    enc_s = 1'b1;
    enc_b = 1'b1;
    ins_s = 1'b1;
    ins_b = 1'b1;
    for (int i = 0; i < 3; i++) begin
      c  = longint'(box_ctr[i]);
      h  = longint'(box_half[i]);
      lo = c - h;
      hi = c + h;
      // gap from the point to the slab on this axis, zero when within
      e = '0;
      if (oc[i] < lo) begin
        e = 128'(lo - oc[i]);
      end else if (oc[i] > hi) begin
        e = 128'(oc[i] - hi);
      end
      acc += e * e;
      d = (c > oc[i]) ? c - oc[i] : oc[i] - c;
      if (d > h + oe[i]) ovl = 1'b0;
      // spheres count by their bounding cube
      if (oc[i] - r < lo || oc[i] + r > hi) enc_s = 1'b0;
      if (oc[i] - oe[i] < lo || oc[i] + oe[i] > hi) enc_b = 1'b0;
      if (oc[i] - r > lo || oc[i] + r < hi) ins_s = 1'b0;
      if (oc[i] - oe[i] > lo || oc[i] + oe[i] < hi) ins_b = 1'b0;
    end
    case (q.func)
      FN_SPHERE_OVERLAP:  hit = (acc <= 128'(r * r));
      FN_BOX_OVERLAP:     hit = ovl;
      FN_ENCLOSES_SPHERE: hit = enc_s;
      FN_ENCLOSES_BOX:    hit = enc_b;
      FN_INSIDE_SPHERE:   hit = ins_s;
      FN_INSIDE_BOX:      hit = ins_b;
      default:            hit = 1'b0;
    endcase
    a.test_true = hit;
    if (acc[127:64] != '0) begin
      a.squared_distance   = '1;
      a.distance_saturated = 1'b1;
    end else begin
      a.squared_distance   = acc[63:0];
      a.distance_saturated = 1'b0;
    end
    return a;
  endfunction

  // mix of raw noise, values on and next to the box faces, and points near the box
  function automatic query_t make_random_query();
    query_t        q;
    logic [CW-1:0] pc [3];
    logic [CW-2:0] pe [3];
    longint        c, h, span, pin;
    int            mode;
    mode = $urandom_range(99);
    for (int i = 0; i < 3; i++) begin
      c = longint'(box_ctr[i]);
      h = longint'(box_half[i]);
      if (mode < 15) begin
        pc[i] = $urandom;
        pe[i] = (CW-1)'($urandom);
      end else if (mode < 30) begin
        case ($urandom_range(5))
          0:       pin = c - h;
          1:       pin = c + h;
          2:       pin = longint'(C_MIN);
          3:       pin = longint'(C_MAX);
          4:       pin = 0;
          default: pin = c;
        endcase
        pc[i] = CW'(pin + int'($urandom_range(2)) - 1);
        case ($urandom_range(3))
          0:       pe[i] = '0;
          1:       pe[i] = E_MAX;
          2:       pe[i] = box_half[i];
          default: pe[i] = (CW-1)'(h + int'($urandom_range(2)) - 1);
        endcase
      end else begin
        span  = 2 * h + (longint'(1) << $urandom_range(20, 2));
        pc[i] = CW'(c + rand_below(2 * span + 1) - span);
        pe[i] = (CW-1)'(rand_below(span + 1));
      end
    end
    q.func = FUNC_W'($urandom_range(7));
    q.cx   = pc[0];
    q.cy   = pc[1];
    q.cz   = pc[2];
    q.ex   = pe[0];
    q.ey   = pe[1];
    q.ez   = pe[2];
    return q;
  endfunction

  function automatic query_t mkq(logic [FUNC_W-1:0] f, logic [CW-1:0] x, y, z,
                                 logic [CW-2:0] ex, ey, ez);
    query_t q;
    q.func = f;
    q.cx   = x;
    q.cy   = y;
    q.cz   = z;
    q.ex   = ex;
    q.ey   = ey;
    q.ez   = ez;
    return q;
  endfunction

  function automatic void add_row(row_kind_t kind, query_t q, bit typed = 1'b0,
                                  answer_t ans = '0);
    stim_row_t row;
    row.kind  = kind;
    row.q     = q;
    row.typed = typed;
    row.ans   = ans;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CW-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_CENTER_X, REG_CENTER_Y, REG_CENTER_Z: box_ctr[idx[1:0]] = value;
      REG_HALF_X, REG_HALF_Y, REG_HALF_Z:
        box_half[2'(idx - REG_HALF_X)] = value[CW-2:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // drain the pipe, then load all six box registers plus one stray index
  task automatic load_box(input logic [CW-1:0] cx, cy, cz, hx, hy, hz);
    @(negedge clk);
    query_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_HALF_X, hx);
    write_reg(REG_HALF_Y, hy);
    write_reg(REG_HALF_Z, hz);
    write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
    @(negedge clk);
    cfg_write <= 1'b0;
    box_settings++;
  endtask

  // offer one query word, holding it until the block takes it
  task automatic send_query(input query_t q, input bit typed, input answer_t typed_ans);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      query_ch.valid <= 1'b0;
      @(negedge clk);
    end
    query_ch.valid          <= 1'b1;
    query_ch.func           <= q.func;
    query_ch.other_center_x <= q.cx;
    query_ch.other_center_y <= q.cy;
    query_ch.other_center_z <= q.cz;
    query_ch.other_extent_x <= q.ex;
    query_ch.other_extent_y <= q.ey;
    query_ch.other_extent_z <= q.ez;
    do @(posedge clk); while (!query_ch.ready);
    pending_answers.insert(pending_answers.size(), typed ? typed_ans : predict_answer(q));
    words_sent++;
  endtask

  task automatic report(input string field, input logic [DIST_W-1:0] want,
                        input logic [DIST_W-1:0] got);
    $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    mismatches++;
  endtask

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        result_ch.ready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // result checker: oldest expectation against each word taken
  always @(posedge clk) begin
    answer_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: result word with nothing pending, got %b %h %b", $time,
                 result_ch.test_true, result_ch.squared_distance,
                 result_ch.distance_saturated);
        mismatches++;
      end else begin
        want = pending_answers.pop_front();
        words_checked++;
        if (result_ch.test_true !== want.test_true)
          report("test_true", DIST_W'(want.test_true), DIST_W'(result_ch.test_true));
        if (result_ch.squared_distance !== want.squared_distance)
          report("squared_distance", want.squared_distance, result_ch.squared_distance);
        if (result_ch.distance_saturated !== want.distance_saturated)
          report("distance_saturated", DIST_W'(want.distance_saturated),
                 DIST_W'(result_ch.distance_saturated));
      end
      if (result_ch.test_true === 1'b1) true_results++;
      if (result_ch.distance_saturated === 1'b1) sat_results++;
    end
  end

  initial begin
    logic [CW-1:0] bc [3];
    logic [CW-1:0] bh [3];
    int            sh;
    int            n;
    int            directed_words;

    rst                     = 1'b1;
    cfg_write               = 1'b0;
    cfg_index               = REG_CENTER_X;
    cfg_data                = '0;
    query_ch.valid          = 1'b0;
    query_ch.func           = FN_SPHERE_OVERLAP;
    query_ch.other_center_x = '0;
    query_ch.other_center_y = '0;
    query_ch.other_center_z = '0;
    query_ch.other_extent_x = '0;
    query_ch.other_extent_y = '0;
    query_ch.other_extent_z = '0;
    for (int i = 0; i < 3; i++) begin
      box_ctr[i]  = '0;
      box_half[i] = '0;
    end

    // directed table: degenerate box at the origin straight after reset
    add_row(ROW_QUERY, mkq(FN_DISTANCE, 0, 0, 0, 0, 0, 0), 1, '{1'b0, 64'd0, 1'b0});
    add_row(ROW_QUERY, mkq(FN_DISTANCE, C_MIN, C_MIN, C_MIN, 0, 0, 0), 1,
            '{1'b0, 64'hC000_0000_0000_0000, 1'b0});
    add_row(ROW_QUERY, mkq(FN_DISTANCE, C_MAX, C_MAX, C_MAX, 0, 0, 0), 1,
            '{1'b0, 64'hBFFF_FFFD_0000_0003, 1'b0});
    // zero-sized volumes on a zero-sized box: every test holds on the boundary
    add_row(ROW_QUERY, mkq(FN_SPHERE_OVERLAP, 0, 0, 0, 0, 0, 0), 1, '{1'b1, 64'd0, 1'b0});
    add_row(ROW_QUERY, mkq(FN_BOX_OVERLAP, 0, 0, 0, 0, 0, 0), 1, '{1'b1, 64'd0, 1'b0});
    add_row(ROW_QUERY, mkq(FN_ENCLOSES_SPHERE, 0, 0, 0, 0, 0, 0), 1, '{1'b1, 64'd0, 1'b0});
    add_row(ROW_QUERY, mkq(FN_ENCLOSES_BOX, 0, 0, 0, 0, 0, 0), 1, '{1'b1, 64'd0, 1'b0});
    add_row(ROW_QUERY, mkq(FN_INSIDE_SPHERE, 0, 0, 0, 0, 0, 0), 1, '{1'b1, 64'd0, 1'b0});
    add_row(ROW_QUERY, mkq(FN_INSIDE_BOX, 0, 0, 0, 0, 0, 0), 1, '{1'b1, 64'd0, 1'b0});
    add_row(ROW_QUERY, mkq(FN_UNUSED, 0, 0, 0, 0, 0, 0), 1, '{1'b0, 64'd0, 1'b0});
    add_row(ROW_QUERY, mkq(FN_SPHERE_OVERLAP, C_MAX, C_MAX, C_MAX, E_MAX, 0, 0));
    add_row(ROW_QUERY, mkq(FN_BOX_OVERLAP, C_MIN, C_MIN, C_MIN, E_MAX, E_MAX, E_MAX));
    add_row(ROW_QUERY, mkq(FN_INSIDE_BOX, 0, 0, 0, E_MAX, E_MAX, E_MAX));
    // point box at the top corner: the far corner overflows the distance
    add_row(ROW_BOX, mkq(FN_DISTANCE, C_MAX, C_MAX, C_MAX, 0, 0, 0));
    add_row(ROW_QUERY, mkq(FN_DISTANCE, C_MIN, C_MIN, C_MIN, 0, 0, 0), 1,
            '{1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1});
    add_row(ROW_QUERY, mkq(FN_ENCLOSES_BOX, C_MAX, C_MAX, C_MAX, 0, 0, 0));
    // widest box at the bottom of the range
    add_row(ROW_BOX, mkq(FN_DISTANCE, C_MIN, C_MIN, C_MIN, E_MAX, E_MAX, E_MAX));
    add_row(ROW_QUERY, mkq(FN_ENCLOSES_SPHERE, C_MIN, C_MIN, C_MIN, E_MAX, 0, 0));
    add_row(ROW_QUERY, mkq(FN_INSIDE_SPHERE, C_MIN, C_MIN, C_MIN, E_MAX, 0, 0));
    add_row(ROW_QUERY, mkq(FN_DISTANCE, C_MAX, C_MAX, C_MAX, 0, 0, 0));
    add_row(ROW_QUERY, mkq(FN_SPHERE_OVERLAP, C_MAX, 0, C_MIN, 0, E_MAX, E_MAX));
    // unit box: touching faces and equal boxes sit right on the inclusive bounds
    add_row(ROW_BOX, mkq(FN_DISTANCE, 0, 0, 0, UNIT, UNIT, UNIT));
    add_row(ROW_QUERY, mkq(FN_BOX_OVERLAP, 2 * UNIT, 0, 0, UNIT, UNIT, UNIT));
    add_row(ROW_QUERY, mkq(FN_INSIDE_BOX, 0, 0, 0, UNIT, UNIT, UNIT));
    add_row(ROW_QUERY, mkq(FN_UNUSED, C_MIN, C_MIN, C_MIN, E_MAX, E_MAX, E_MAX));

    // synchronous reset held, then released on a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_BOX) begin
        load_box(directed_rows[i].q.cx, directed_rows[i].q.cy, directed_rows[i].q.cz,
                 {1'b0, directed_rows[i].q.ex}, {1'b0, directed_rows[i].q.ey},
                 {1'b0, directed_rows[i].q.ez});
      end else begin
        send_query(directed_rows[i].q, directed_rows[i].typed, directed_rows[i].ans);
      end
    end
    directed_words = words_sent;

    // random phases, each against a fresh box; the top bit of the half data is junk
    for (int p = 0; p < NUM_PHASES; p++) begin
      for (int a = 0; a < 3; a++) begin
        sh = $urandom_range(31, 2);
        if (p == 0) begin
          case ($urandom_range(2))
            0:       bc[a] = C_MIN;
            1:       bc[a] = C_MAX;
            default: bc[a] = '0;
          endcase
          bh[a] = {1'($urandom), $urandom_range(1) ? E_MAX : '0};
        end else if (p == 1) begin
          bc[a] = '0;
          bh[a] = '0;
        end else if (p == NUM_PHASES - 1) begin
          bc[a] = $urandom;
          bh[a] = {1'($urandom), E_MAX};
        end else begin
          bc[a] = CW'($signed($urandom) >>> (32 - sh));
          bh[a] = {1'($urandom), (CW-1)'($urandom >> (33 - sh))};
        end
      end
      load_box(bc[0], bc[1], bc[2], bh[0], bh[1], bh[2]);
      // one phase back to back on both sides, one with a long result hold-off
      gaps_on = (p != QUIET_PHASE);
      if (p == PRESSURE_PHASE) hold_request = 1'b1;
      repeat (ITEMS_PER_PHASE) send_query(make_random_query(), 1'b0, '0);
    end
    gaps_on = 1'b1;

    @(negedge clk);
    query_ch.valid <= 1'b0;
    for (n = 0; n < 2000 && pending_answers.size() != 0; n++) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (pending_answers.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, pending_answers.size());
      mismatches += pending_answers.size();
    end

    $display("summary: %0d query words (%0d directed) over %0d box settings, %0d reg writes",
             words_sent, directed_words, box_settings, reg_writes);
    $display("summary: %0d words checked, %0d tests true, %0d distances clipped, %0d errors",
             words_checked, true_results, sat_results, mismatches);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/aoet_pkg.sv
rtl/core/aoet_if.sv
rtl/core/aoet_axis.sv
rtl/core/aoet_eval.sv
rtl/core/aabb_overlap_enclosure_test_top.sv
sim/tb.sv
